### sv/modular_arithmetic_unit_top_assert.svh
// Assertion macros for the modular arithmetic unit top level
`ifndef MODULAR_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define MODULAR_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MAU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MAU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### sv/mau_pkg.sv
// Types and constants shared by the modular arithmetic unit
package mau_pkg;

	// port field widths and packing offsets
	localparam int OPER_W    = 31;
	localparam int EXP_W     = 63;
	localparam int RAW_W     = 64;
	localparam int CMD_W     = 3;
	localparam int ERR_W     = 2;
	localparam int S_DATA_W  = 192;
	localparam int M_DATA_W  = 32;
	localparam int A_LSB     = 0;
	localparam int B_LSB     = 31;
	localparam int EXP_LSB   = 62;
	localparam int RAW_LSB   = 125;

	// dividend width of the shared divider
	localparam int DVD_W     = 64;

	localparam logic [OPER_W-1:0] MOD_RESET = 31'd998244353;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_INV = 3'd4,
		CMD_POW = 3'd5,
		CMD_NEG = 3'd6,
		CMD_RAW = 3'd7
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_ZERO  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_MUL,
		ST_DIV,
		ST_POST,
		ST_EUC_CHK,
		ST_EUC_MUL,
		ST_EUC_UPD,
		ST_INV_FIN,
		ST_POW_CHK,
		ST_POW_SQ,
		ST_DONE
	} state_t;

	// what to do with the divider output
	typedef enum logic [2:0] {
		PH_MULRES,
		PH_RAW,
		PH_EUC,
		PH_POW_ACC,
		PH_POW_SQ
	} phase_t;

endpackage

### sv/modular_arithmetic_unit_top.sv
// Modular arithmetic unit: add, sub, mul, div, inverse, power, negate, reduce
// Add, subtract, negate and range or zero errors skip the divider; mul, reduce,
// inverse (Euclid steps), divide (inverse then multiply) and power (square and
// multiply per exponent bit) all use the one-bit-per-cycle restoring divider that
// every reduction shares.
// One item at a time. Reset clears control and loads modulus 998244353.
`include "modular_arithmetic_unit_top_assert.svh"

module modular_arithmetic_unit_top #(
	parameter int MOD_BITS = 31,
	parameter int EXP_BITS = 63
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// operand_a, operand_b, exponent, raw_value, zero pad
	input  logic [mau_pkg::S_DATA_W-1:0]     s_tdata,
	// cmd
	input  logic [mau_pkg::CMD_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// result, zero pad
	output logic [mau_pkg::M_DATA_W-1:0]     m_tdata,
	// error
	output logic [mau_pkg::ERR_W-1:0]        m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mau_pkg::OPER_W-1:0]       cfg_data
);

	localparam int MB    = MOD_BITS;
	localparam int CW    = MB + 2;
	localparam int PW    = 2 * MB + 3;
	localparam int DW    = mau_pkg::DVD_W;
	localparam int CNT_W = $clog2(DW + 1);

	mau_pkg::state_t state_q, state_d;
	mau_pkg::phase_t phase_q;
	mau_pkg::cmd_t   cmd_q;
	mau_pkg::err_t   err_q;

	logic [MB-1:0]                 mod_q;
	logic [mau_pkg::OPER_W-1:0]    a_q, b_q;
	logic [EXP_BITS-1:0]           e_q;
	logic [mau_pkg::RAW_W-1:0]     raw_q;
	logic                          neg_q;
	logic [MB-1:0]                 acc_q, base_q, mx_q, my_q, r0_q, r1_q;
	logic [MB-1:0]                 divisor_q, rem_q, res_q;
	logic signed [CW-1:0]          c0_q, c1_q;
	logic [DW-1:0]                 dvd_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [mau_pkg::OPER_W-1:0]    mres_q;
	mau_pkg::err_t                 merr_q;
	logic                          mv_q;

	logic [MB-1:0]                 m_eff, an, bn;
	logic [mau_pkg::OPER_W-1:0]    m_ext;
	logic                          a_bad, b_bad, needs_b, bad;
	logic [MB:0]                   add_s;
	logic [MB-1:0]                 add_r, sub_r, neg_r, raw_r, inv_r;
	logic [DW-1:0]                 raw_mag;
	logic signed [MB:0]            mul_x;
	logic signed [CW-1:0]          mul_y, m_s, inv_t;
	logic signed [PW-1:0]          prod;
	logic [MB:0]                   rem_sh;
	logic                          ge;
	logic [MB-1:0]                 rem_nx;
	logic [EXP_BITS-1:0]           e_sh;

	// effective modulus and operand checks
	assign m_eff   = (mod_q < MB'(2)) ? MB'(2) : mod_q;
	assign m_ext   = mau_pkg::OPER_W'(m_eff);
	assign an      = a_q[MB-1:0];
	assign bn      = b_q[MB-1:0];
	assign a_bad   = a_q >= m_ext;
	assign b_bad   = b_q >= m_ext;
	assign needs_b = (cmd_q == mau_pkg::CMD_ADD) || (cmd_q == mau_pkg::CMD_SUB) ||
	                 (cmd_q == mau_pkg::CMD_MUL) || (cmd_q == mau_pkg::CMD_DIV);
	assign bad     = a_bad || (needs_b && b_bad);

	// combinational add, subtract, negate
	assign add_s = {1'b0, an} + {1'b0, bn};
	assign add_r = (add_s >= {1'b0, m_eff}) ? MB'(add_s - {1'b0, m_eff}) : add_s[MB-1:0];
	assign sub_r = (an >= bn) ? (an - bn) : MB'({1'b0, an} + {1'b0, m_eff} - {1'b0, bn});
	assign neg_r = (an != '0) ? (m_eff - an) : '0;

	// magnitude of the signed raw value
	assign raw_mag = raw_q[mau_pkg::RAW_W-1] ? (~raw_q + 1'b1) : raw_q;
	assign raw_r   = (rem_q == '0) ? '0 : (neg_q ? (m_eff - rem_q) : rem_q);

	// shared multiplier: residues or quotient times Euclid coefficient
	assign mul_x = $signed({1'b0, mx_q});
	assign mul_y = (state_q == mau_pkg::ST_EUC_MUL) ? c1_q : $signed({2'b00, my_q});
	assign prod  = mul_x * mul_y;

	// shared restoring divider step
	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign ge     = rem_sh >= {1'b0, divisor_q};
	assign rem_nx = ge ? MB'(rem_sh - {1'b0, divisor_q}) : rem_sh[MB-1:0];

	// fold the final Euclid coefficient into range
	assign m_s   = $signed({2'b00, m_eff});
	assign inv_t = c0_q[CW-1] ? (c0_q + m_s) : ((c0_q >= m_s) ? (c0_q - m_s) : c0_q);
	assign inv_r = inv_t[MB-1:0];

	assign e_sh = e_q >> 1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mau_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = mau_pkg::ST_DISP;
			end
			mau_pkg::ST_DISP: begin
				if (cmd_q == mau_pkg::CMD_RAW) begin
					state_d = mau_pkg::ST_DIV;
				end else if (bad) begin
					state_d = mau_pkg::ST_DONE;
				end else begin
					case (cmd_q)
						mau_pkg::CMD_MUL: state_d = mau_pkg::ST_MUL;
						mau_pkg::CMD_DIV: state_d = (bn == '0) ? mau_pkg::ST_DONE
						                                       : mau_pkg::ST_EUC_CHK;
						mau_pkg::CMD_INV: state_d = (an == '0) ? mau_pkg::ST_DONE
						                                       : mau_pkg::ST_EUC_CHK;
						mau_pkg::CMD_POW: state_d = mau_pkg::ST_POW_CHK;
						default:          state_d = mau_pkg::ST_DONE;
					endcase
				end
			end
			mau_pkg::ST_MUL: state_d = mau_pkg::ST_DIV;
			mau_pkg::ST_DIV: begin
				if (cnt_q == CNT_W'(1)) state_d = mau_pkg::ST_POST;
			end
			mau_pkg::ST_POST: begin
				case (phase_q)
					mau_pkg::PH_EUC:     state_d = mau_pkg::ST_EUC_MUL;
					mau_pkg::PH_POW_ACC: state_d = mau_pkg::ST_POW_SQ;
					mau_pkg::PH_POW_SQ:  state_d = mau_pkg::ST_POW_CHK;
					default:             state_d = mau_pkg::ST_DONE;
				endcase
			end
			mau_pkg::ST_EUC_CHK: begin
				state_d = (r1_q == '0) ? mau_pkg::ST_INV_FIN : mau_pkg::ST_DIV;
			end
			mau_pkg::ST_EUC_MUL: state_d = mau_pkg::ST_EUC_UPD;
			mau_pkg::ST_EUC_UPD: state_d = mau_pkg::ST_EUC_CHK;
			mau_pkg::ST_INV_FIN: begin
				state_d = (cmd_q == mau_pkg::CMD_INV) ? mau_pkg::ST_DONE : mau_pkg::ST_MUL;
			end
			mau_pkg::ST_POW_CHK: begin
				if (e_q == '0) state_d = mau_pkg::ST_DONE;
				else if (e_q[0]) state_d = mau_pkg::ST_MUL;
				else state_d = mau_pkg::ST_POW_SQ;
			end
			mau_pkg::ST_POW_SQ: begin
				state_d = (e_sh == '0) ? mau_pkg::ST_DONE : mau_pkg::ST_MUL;
			end
			mau_pkg::ST_DONE: begin
				if (!mv_q || m_tready) state_d = mau_pkg::ST_IDLE;
			end
			default: state_d = mau_pkg::ST_IDLE;
		endcase
	end

	// datapath: operands, divider, Euclid and power registers
	always_ff @(posedge clk) begin
		case (state_q)
			mau_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd_q <= mau_pkg::cmd_t'(s_tuser);
					a_q   <= s_tdata[mau_pkg::A_LSB +: mau_pkg::OPER_W];
					b_q   <= s_tdata[mau_pkg::B_LSB +: mau_pkg::OPER_W];
					e_q   <= s_tdata[mau_pkg::EXP_LSB +: EXP_BITS];
					raw_q <= s_tdata[mau_pkg::RAW_LSB +: mau_pkg::RAW_W];
				end
			end
			mau_pkg::ST_DISP: begin
				err_q <= mau_pkg::ERR_OK;
				res_q <= '0;
				neg_q <= raw_q[mau_pkg::RAW_W-1];
				if (cmd_q == mau_pkg::CMD_RAW) begin
					dvd_q     <= raw_mag;
					cnt_q     <= CNT_W'(DW);
					rem_q     <= '0;
					divisor_q <= m_eff;
					phase_q   <= mau_pkg::PH_RAW;
				end else if (bad) begin
					err_q <= mau_pkg::ERR_RANGE;
				end else begin
					case (cmd_q)
						mau_pkg::CMD_ADD: res_q <= add_r;
						mau_pkg::CMD_SUB: res_q <= sub_r;
						mau_pkg::CMD_NEG: res_q <= neg_r;
						mau_pkg::CMD_MUL: begin
							mx_q    <= an;
							my_q    <= bn;
							phase_q <= mau_pkg::PH_MULRES;
						end
						mau_pkg::CMD_DIV: begin
							if (bn == '0) err_q <= mau_pkg::ERR_ZERO;
							r0_q <= bn;
							r1_q <= m_eff;
							c0_q <= CW'(1);
							c1_q <= '0;
						end
						mau_pkg::CMD_INV: begin
							if (an == '0) err_q <= mau_pkg::ERR_ZERO;
							r0_q <= an;
							r1_q <= m_eff;
							c0_q <= CW'(1);
							c1_q <= '0;
						end
						mau_pkg::CMD_POW: begin
							acc_q  <= MB'(1);
							base_q <= an;
						end
						default: res_q <= '0;
					endcase
				end
			end
			mau_pkg::ST_MUL: begin
				dvd_q     <= DW'(prod[2*MB-1:0]) << (DW - 2 * MB);
				cnt_q     <= CNT_W'(2 * MB);
				rem_q     <= '0;
				divisor_q <= m_eff;
			end
			mau_pkg::ST_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[DW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			mau_pkg::ST_POST: begin
				case (phase_q)
					mau_pkg::PH_MULRES: res_q <= rem_q;
					mau_pkg::PH_RAW:    res_q <= raw_r;
					mau_pkg::PH_EUC: begin
						r0_q <= r1_q;
						r1_q <= rem_q;
						mx_q <= dvd_q[MB-1:0];
					end
					mau_pkg::PH_POW_ACC: acc_q  <= rem_q;
					mau_pkg::PH_POW_SQ:  base_q <= rem_q;
					default:             res_q  <= rem_q;
				endcase
			end
			mau_pkg::ST_EUC_CHK: begin
				if (r1_q != '0) begin
					dvd_q     <= DW'(r0_q) << (DW - MB);
					cnt_q     <= CNT_W'(MB);
					rem_q     <= '0;
					divisor_q <= r1_q;
					phase_q   <= mau_pkg::PH_EUC;
				end
			end
			mau_pkg::ST_EUC_MUL: begin
				dvd_q <= DW'(prod[CW-1:0]);
			end
			mau_pkg::ST_EUC_UPD: begin
				c0_q <= c1_q;
				c1_q <= c0_q - $signed(dvd_q[CW-1:0]);
			end
			mau_pkg::ST_INV_FIN: begin
				if (cmd_q == mau_pkg::CMD_INV) begin
					res_q <= inv_r;
				end else begin
					mx_q    <= an;
					my_q    <= inv_r;
					phase_q <= mau_pkg::PH_MULRES;
				end
			end
			mau_pkg::ST_POW_CHK: begin
				if (e_q == '0) begin
					res_q <= acc_q;
				end else if (e_q[0]) begin
					mx_q    <= acc_q;
					my_q    <= base_q;
					phase_q <= mau_pkg::PH_POW_ACC;
				end
			end
			mau_pkg::ST_POW_SQ: begin
				e_q <= e_sh;
				if (e_sh == '0) begin
					res_q <= acc_q;
				end else begin
					mx_q    <= base_q;
					my_q    <= base_q;
					phase_q <= mau_pkg::PH_POW_SQ;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= mau_pkg::MOD_RESET[MB-1:0];
		end else if (cfg_valid) begin
			mod_q <= cfg_data[MB-1:0];
		end
	end

	// output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (state_q == mau_pkg::ST_DONE && (!mv_q || m_tready)) begin
			mv_q <= 1'b1;
		end else if (m_tready) begin
			mv_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == mau_pkg::ST_DONE && (!mv_q || m_tready)) begin
			mres_q <= mau_pkg::OPER_W'(res_q);
			merr_q <= err_q;
		end
	end

	assign s_tready  = (state_q == mau_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = mv_q;
	assign m_tdata   = {1'b0, mres_q};
	assign m_tuser   = merr_q;

	// checks
	`MAU_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`MAU_ASSERT_IMPL(a_error_zero_result, m_tvalid && (m_tuser != mau_pkg::ERR_OK), m_tdata == '0)
	`MAU_ASSERT_IMPL(a_divisor_nonzero, state_q == mau_pkg::ST_DIV, divisor_q != '0)

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the modular arithmetic unit top level
module testbench;

	// Predicts each residue and error code and holds them until the block answers
	class residue_book;
		typedef struct {
			logic [mau_pkg::OPER_W-1:0] res;
			mau_pkg::err_t              err;
		} answer_t;

		answer_t                    expected_answers[$];
		logic [mau_pkg::OPER_W-1:0] mod_reg = mau_pkg::MOD_RESET;
		int                         failures = 0;

		function longint unsigned eff_mod();
			return (mod_reg < 2) ? 64'd2 : 64'(mod_reg);
		endfunction

		function longint unsigned reduce_signed(longint unsigned u, longint unsigned m);
			longint unsigned mag, r;
			if (u[63]) begin
				mag = ~u + 64'd1;
				r = mag % m;
				return (r != 0) ? m - r : 64'd0;
			end
			return u % m;
		endfunction

		function longint unsigned euclid_inverse(longint unsigned a, longint unsigned m);
			longint r0, r1, c0, c1, q, t;
			r0 = a; r1 = m; c0 = 1; c1 = 0;
			while (r1 != 0) begin
				q = r0 / r1;
				t = r0 - q * r1;
				r0 = r1; r1 = t;
				t = c0 - q * c1;
				c0 = c1; c1 = t;
			end
			return reduce_signed(c0, m);
		endfunction

		function longint unsigned power_mod(longint unsigned a,
				logic [mau_pkg::EXP_W-1:0] e, longint unsigned m);
			longint unsigned acc, base;
			acc = 1 % m; base = a;
			while (e != 0) begin
				if (e[0]) acc = (acc * base) % m;
				base = (base * base) % m;
				e = e >> 1;
			end
			return acc;
		endfunction

		// work out the answer of one accepted item and queue it
		function void note_item(mau_pkg::cmd_t cmd, logic [mau_pkg::OPER_W-1:0] a,
				logic [mau_pkg::OPER_W-1:0] b, logic [mau_pkg::EXP_W-1:0] e,
				logic [mau_pkg::RAW_W-1:0] raw);
			longint unsigned m, ua, ub, r;
			answer_t ans;
			m = eff_mod(); ua = a; ub = b; r = 0;
			ans.err = mau_pkg::ERR_OK;
			if (cmd != mau_pkg::CMD_RAW && (ua >= m || (cmd <= mau_pkg::CMD_DIV && ub >= m)))
			begin
				ans.err = mau_pkg::ERR_RANGE;
			end else begin
				case (cmd)
					mau_pkg::CMD_ADD: r = (ua + ub) % m;
					mau_pkg::CMD_SUB: r = (ua >= ub) ? ua - ub : ua + m - ub;
					mau_pkg::CMD_MUL: r = (ua * ub) % m;
					mau_pkg::CMD_DIV: begin
						if (ub == 0) ans.err = mau_pkg::ERR_ZERO;
						else r = (ua * euclid_inverse(ub, m)) % m;
					end
					mau_pkg::CMD_INV: begin
						if (ua == 0) ans.err = mau_pkg::ERR_ZERO;
						else r = euclid_inverse(ua, m);
					end
					mau_pkg::CMD_POW: r = power_mod(ua, e, m);
					mau_pkg::CMD_NEG: r = (ua != 0) ? m - ua : 64'd0;
					default: r = reduce_signed(raw, m);
				endcase
			end
			if (ans.err != mau_pkg::ERR_OK) r = 0;
			ans.res = r[mau_pkg::OPER_W-1:0];
			expected_answers.push_back(ans);
		endfunction

		// compare one result with the oldest answer waiting
		function void check_item(logic [mau_pkg::OPER_W-1:0] res,
				logic [mau_pkg::ERR_W-1:0] err);
			answer_t ans;
			if (expected_answers.size() == 0) begin
				$error("result with none expected: result %0d, error %0d", res, err);
				failures++;
				return;
			end
			ans = expected_answers.pop_front();
			if (res !== ans.res) begin
				$error("result: expected %0d, actual %0d", ans.res, res);
				failures++;
			end
			if (err !== ans.err) begin
				$error("error: expected %0d, actual %0d", ans.err, err);
				failures++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [mau_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic [mau_pkg::CMD_W-1:0]      s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [mau_pkg::M_DATA_W-1:0]   m_tdata;
	logic [mau_pkg::ERR_W-1:0]      m_tuser;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [mau_pkg::OPER_W-1:0]     cfg_data = '0;

	residue_book book = new();
	bit quiet = 0;
	bit hold_req = 0;
	int hold_left = 0;
	int stall_left = 0;

	modular_arithmetic_unit_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receive results: check, then pick the ready level for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) book.check_item(m_tdata[mau_pkg::OPER_W-1:0], m_tuser);
			if (hold_req) begin
				hold_req = 0;
				hold_left = 3000;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one item, hold it until accepted, then note it
	task automatic send_item(mau_pkg::cmd_t cmd, logic [mau_pkg::OPER_W-1:0] a,
			logic [mau_pkg::OPER_W-1:0] b, logic [mau_pkg::EXP_W-1:0] e,
			logic [mau_pkg::RAW_W-1:0] raw);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {3'b000, raw, e, b, a};
		do @(posedge clk); while (!s_tready);
		book.note_item(cmd, a, b, e, raw);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (book.expected_answers.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Write the modulus once the block is idle
	task automatic write_modulus(logic [mau_pkg::OPER_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.mod_reg = value;
		@(posedge clk);
	endtask

	function automatic logic [mau_pkg::OPER_W-1:0] pick_operand();
		longint unsigned m;
		m = book.eff_mod();
		if ($urandom_range(0, 9) == 0) return mau_pkg::OPER_W'($urandom);
		if ($urandom_range(0, 19) == 0) return mau_pkg::OPER_W'(m - 1);
		return mau_pkg::OPER_W'($urandom_range(int'(m - 1), 0));
	endfunction

	task automatic send_random();
		mau_pkg::cmd_t cmd;
		logic [mau_pkg::EXP_W-1:0] e;
		logic [mau_pkg::RAW_W-1:0] raw;
		cmd = mau_pkg::cmd_t'($urandom_range(0, 7));
		if ($urandom_range(0, 6) == 0) e = mau_pkg::EXP_W'({$urandom, $urandom});
		else e = mau_pkg::EXP_W'($urandom_range(0, 40));
		raw = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0) raw = {{32{raw[63]}}, raw[31:0]};
		send_item(cmd, pick_operand(), pick_operand(), e, raw);
	endtask

	logic [mau_pkg::OPER_W-1:0] moduli[8] = '{31'd998244353, 31'd2147483647, 31'd2, 31'd0,
		31'd1000, 31'd1000000007, 31'd65536, 31'd3};

	initial begin
		logic [mau_pkg::OPER_W-1:0] mx;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes and special cases at the reset modulus
		mx = mau_pkg::MOD_RESET - 31'd1;
		send_item(mau_pkg::CMD_ADD, mx, mx, '0, '0);
		send_item(mau_pkg::CMD_SUB, '0, mx, '0, '0);
		send_item(mau_pkg::CMD_MUL, mx, mx, '1, '1);
		send_item(mau_pkg::CMD_DIV, 31'd5, '0, '0, '0);
		send_item(mau_pkg::CMD_DIV, mx, 31'd7, '0, '0);
		send_item(mau_pkg::CMD_INV, '0, '1, '0, '0);
		send_item(mau_pkg::CMD_INV, 31'd1, '0, '0, '0);
		send_item(mau_pkg::CMD_INV, mx, '1, '0, '0);
		send_item(mau_pkg::CMD_POW, '0, '0, '0, '0);
		send_item(mau_pkg::CMD_POW, 31'd3, '0, '1, '0);
		send_item(mau_pkg::CMD_POW, mx, '1, 63'd2, '1);
		send_item(mau_pkg::CMD_NEG, '0, '1, '0, '0);
		send_item(mau_pkg::CMD_NEG, 31'd1, '0, '0, '0);
		send_item(mau_pkg::CMD_RAW, '1, '1, '1, 64'h8000_0000_0000_0000);
		send_item(mau_pkg::CMD_RAW, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(mau_pkg::CMD_RAW, '0, '0, '0, '1);
		send_item(mau_pkg::CMD_ADD, mau_pkg::MOD_RESET, '0, '0, '0);
		send_item(mau_pkg::CMD_SUB, '0, mau_pkg::MOD_RESET, '0, '0);
		send_item(mau_pkg::CMD_MUL, '1, '1, '0, '0);
		send_item(mau_pkg::CMD_NEG, '1, '0, '0, '0);
		send_item(mau_pkg::CMD_POW, '1, '0, '0, '0);
		send_item(mau_pkg::CMD_DIV, '0, '0, '0, '0);

		// random phases, one per modulus setting
		foreach (moduli[p]) begin
			write_modulus(moduli[p]);
			if (p == 7) quiet = 1;
			for (int i = 0; i < 166; i++) begin
				if (p == 1 && i == 20) hold_req = 1;
				if (p == 2 && i == 50) drain();
				send_random();
			end
		end

		drain();
		repeat (200) @(posedge clk);
		if (book.failures == 0 && book.expected_answers.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#480000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

### modular_arithmetic_unit_top.f
+incdir+sv
sv/mau_pkg.sv
sv/modular_arithmetic_unit_top.sv
tb/sv/testbench.sv
